### rtl/core/oidsd_pkg.sv
// ----------------------------------------------------------------------------
// oidsd_pkg
// shared widths, beat types and the divide-by-40 helpers of the oid decoder
// ----------------------------------------------------------------------------
package oidsd_pkg;

    localparam int ARC_WIDTH = 32;   // accumulator width, 8 to 64
    localparam int OCTET_W   = 8;
    localparam int SUB_ID_W  = 32;
    localparam int DIGIT_W   = 7;    // payload bits of one content octet
    localparam int FIRST_DIV = 40;   // first octet packs two arcs as x*40+y

    typedef struct packed {
        logic [SUB_ID_W-1:0] sub_id;
        logic                ident_end;
        logic                last_run;
    } result_t;

    typedef struct packed {
        logic    none;    // octet gives no result
        logic    two;     // octet gives two results
        result_t r0;
        result_t r1;
    } dec_t;

    // x / 40 for an octet: (x >> 3) / 5 via reciprocal 13/64, exact for all x in 0..255
    function automatic logic [OCTET_W-1:0] div40(input logic [OCTET_W-1:0] x);
        logic [4:0]  t;
        logic [8:0]  p;
        t = x[7:3];
        p = 9'(t) * 9'd13;
        return OCTET_W'(p[8:6]);
    endfunction

    function automatic logic [OCTET_W-1:0] mod40(input logic [OCTET_W-1:0] x,
                                                 input logic [OCTET_W-1:0] q);
        logic [OCTET_W-1:0] m;
        m = OCTET_W'(q * OCTET_W'(FIRST_DIV));
        return x - m;
    endfunction

endpackage

### rtl/core/oidsd_arc_unit.sv
// ----------------------------------------------------------------------------
// oidsd_arc_unit
// arc accumulator register and per-octet decode logic
// ----------------------------------------------------------------------------
module oidsd_arc_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,   // item leaves input register
    input  logic [oidsd_pkg::OCTET_W-1:0]     octet,
    input  logic                              first,
    input  logic                              last,
    output oidsd_pkg::dec_t                   dec
);
    import oidsd_pkg::*;

    logic [ARC_WIDTH-1:0]          acc_reg;
    logic [ARC_WIDTH-1:0]          acc_next;
    logic [ARC_WIDTH-1:0]          acc_sum;
    logic [ARC_WIDTH+SUB_ID_W-1:0] acc_ext;
    logic [OCTET_W-1:0]            quo;
    logic [OCTET_W-1:0]            rem;

    assign acc_sum = acc_reg + ARC_WIDTH'(octet[DIGIT_W-1:0]);
    assign acc_ext = {{SUB_ID_W{1'b0}}, acc_sum};
    assign quo     = div40(octet);
    assign rem     = mod40(octet, quo);

    always_comb begin
        dec       = '0;
        acc_next  = acc_reg;
        if (first) begin
            acc_next            = '0;
            dec.two             = 1'b1;
            dec.r0.sub_id       = SUB_ID_W'(quo);
            dec.r0.ident_end    = last;
            dec.r0.last_run     = 1'b0;
            dec.r1.sub_id       = SUB_ID_W'(rem);
            dec.r1.ident_end    = last;
            dec.r1.last_run     = 1'b1;
        end else if (!octet[DIGIT_W]) begin
            acc_next            = '0;
            dec.r0.sub_id       = acc_ext[SUB_ID_W-1:0];
            dec.r0.ident_end    = last;
            dec.r0.last_run     = 1'b1;
        end else begin
            // continuation octet; a partial arc at the final octet is dropped
            dec.none            = 1'b1;
            acc_next            = last ? '0 : (acc_sum << DIGIT_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (advance) begin
            acc_reg <= acc_next;
        end
    end

endmodule

### rtl/core/oidsd_out_buffer.sv
// ----------------------------------------------------------------------------
// oidsd_out_buffer
// two-entry result holder driving the master stream
// ----------------------------------------------------------------------------
module oidsd_out_buffer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  oidsd_pkg::dec_t                  dec,
    output logic                             can_load,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [oidsd_pkg::SUB_ID_W-1:0]   m_tdata,   // sub_identifier
    output logic                             m_tlast,   // identifier_end
    output logic                             m_tuser    // last_of_run
);
    import oidsd_pkg::*;

    result_t head_reg;
    result_t tail_reg;
    logic    head_valid_reg;
    logic    tail_valid_reg;
    logic    pop;

    assign pop      = head_valid_reg && m_tready;
    assign can_load = !head_valid_reg || (m_tready && !tail_valid_reg);

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = head_reg.sub_id;
    assign m_tlast  = head_reg.ident_end;
    assign m_tuser  = head_reg.last_run;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end else if (load) begin
            head_valid_reg <= 1'b1;
            tail_valid_reg <= dec.two;
        end else if (pop) begin
            head_valid_reg <= tail_valid_reg;
            tail_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            head_reg <= dec.r0;
            tail_reg <= dec.r1;
        end else if (pop && tail_valid_reg) begin
            head_reg <= tail_reg;
        end
    end

endmodule

### rtl/core/oid_subidentifier_decoder_unit.sv
// ----------------------------------------------------------------------------
// oid_subidentifier_decoder_unit
// decodes object identifier content octets into sub-identifier arcs
// ----------------------------------------------------------------------------
// usage
//   slave stream: one content octet per beat in s_tdata, s_tuser marks the
//   first octet of an identifier, s_tlast marks its final octet
//   master stream: one arc per beat in m_tdata, m_tlast copies the final-octet
//   flag of the octet that caused it, m_tuser marks the last arc of that octet
//   the first octet gives two beats: octet / 40, then octet mod 40
//   a continuation octet (bit 7 set) gives no beat; at a final octet its
//   partial arc is dropped
// path: an octet is held in the input register, its results in the output buffer
// throughput: one octet per cycle while m_tready is high; a first octet fills
//   both entries; a later result octet waits until the second beat leaves
// reset: aresetn low clears the input register, the output buffer and the
//   arc accumulator
// stall: when m_tready is low the two-entry output buffer holds its beats,
//   one more octet waits in the input register, then s_tready drops
// ----------------------------------------------------------------------------
module oid_subidentifier_decoder_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [oidsd_pkg::OCTET_W-1:0]    s_tdata,   // content_byte
    input  logic                             s_tlast,   // last_byte
    input  logic                             s_tuser,   // first_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [oidsd_pkg::SUB_ID_W-1:0]   m_tdata,   // sub_identifier
    output logic                             m_tlast,   // identifier_end
    output logic                             m_tuser    // last_of_run
);
    import oidsd_pkg::*;

    // input register
    logic               in_valid_reg;
    logic [OCTET_W-1:0] in_octet_reg;
    logic               in_first_reg;
    logic               in_last_reg;

    dec_t dec;
    logic can_load;
    logic advance;   // registered octet is decoded this cycle

    // octets without a result never wait on the output side
    assign advance  = in_valid_reg && (dec.none || can_load);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_octet_reg <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // accumulator and arc decode
    oidsd_arc_unit u_arc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .octet   (in_octet_reg),
        .first   (in_first_reg),
        .last    (in_last_reg),
        .dec     (dec)
    );

    // result beats toward the master side
    oidsd_out_buffer u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && !dec.none),
        .dec      (dec),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
